// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies expr on the same clock edge.
`define OSP_ASSERT_IMP(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// Check that cond implies expr on the next clock edge.
`define OSP_ASSERT_NXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

// ===== src/osp_pkg.sv =====
package osp_pkg;

  // Field widths
  localparam int RADIUS_W = 18;
  localparam int HEIGHT_W = 24;
  localparam int POS_W    = 19;
  localparam int FRAME_W  = 16;

  // Parameter defaults
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [FRAME_W-1:0] FRAME_TIME_RST = 16'd1074;

  // Square root operand: (radius + 1.0) in Q.32, root in Q.16
  localparam int RAD_FRAC  = 24;
  localparam int SQRT_IN_W = 44;
  localparam int ROOT_W    = SQRT_IN_W / 2;
  localparam logic [ROOT_W-1:0] ROOT_MIN = ROOT_W'(65536);
  localparam logic [RADIUS_W:0] RADIUS_ONE = (RADIUS_W+1)'(256);

  // frame_time * round(2^32/pi)
  localparam int PROD_W = 47;
  localparam logic [PROD_W-1:0] INV_PI = PROD_W'(1367130551);

  // Dividend is the product shifted up by NUM_SHIFT; quotient stays below 2^QUOT_TOP
  localparam int NUM_SHIFT = 16;
  localparam int QUOT_TOP  = 47;
  localparam int PRE_W     = QUOT_TOP - (PROD_W - 1 - 0) + PROD_W - NUM_SHIFT - 15;

  // CORDIC in Q2.30, angles in turns of 2^32
  localparam int TURN_W = 32;
  localparam int TRIG_W = 32;
  localparam int TRIG_FRAC = 30;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam int ATAN_N = 24;
  localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Quadrant codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

endpackage

// ===== src/osp_sqrt_pipe.sv =====
`include "assert_macros.svh"

module osp_sqrt_pipe #(
  parameter int TAG_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [osp_pkg::SQRT_IN_W-1:0] in_rad,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_valid,
  output logic [osp_pkg::ROOT_W-1:0]    out_root,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int STAGES = osp_pkg::ROOT_W;
  localparam int REM_W  = osp_pkg::ROOT_W + 2;

  logic                          valid [1:STAGES];
  logic [osp_pkg::SQRT_IN_W-1:0] rad   [1:STAGES];
  logic [REM_W-1:0]              rem   [1:STAGES];
  logic [osp_pkg::ROOT_W-1:0]    root  [1:STAGES];
  logic [TAG_W-1:0]              tag   [1:STAGES];

  // One root bit per stage, two radicand bits consumed
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                          cur_valid;
    logic [osp_pkg::SQRT_IN_W-1:0] cur_rad;
    logic [REM_W-1:0]              cur_rem;
    logic [osp_pkg::ROOT_W-1:0]    cur_root;
    logic [TAG_W-1:0]              cur_tag;
    logic [REM_W+1:0]              rem_sh;
    logic [REM_W+1:0]              trial;
    logic [REM_W+1:0]              diff;

    if (i == 0) begin : g_first
      assign cur_valid = in_valid;
      assign cur_rad   = in_rad;
      assign cur_rem   = '0;
      assign cur_root  = '0;
      assign cur_tag   = in_tag;
    end else begin : g_rest
      assign cur_valid = valid[i];
      assign cur_rad   = rad[i];
      assign cur_rem   = rem[i];
      assign cur_root  = root[i];
      assign cur_tag   = tag[i];
    end

    assign rem_sh = {cur_rem, cur_rad[osp_pkg::SQRT_IN_W-1-2*i -: 2]};
    assign trial  = {2'b00, cur_root, 2'b01};
    assign diff   = rem_sh - trial;

    // Advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= cur_valid;
      end
    end

    // Subtract the trial when it fits, else keep the shifted remainder
    always_ff @(posedge clk) begin
      rad[i+1] <= cur_rad;
      tag[i+1] <= cur_tag;
      if (rem_sh >= trial) begin
        rem[i+1]  <= diff[REM_W-1:0];
        root[i+1] <= {cur_root[osp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem[i+1]  <= rem_sh[REM_W-1:0];
        root[i+1] <= {cur_root[osp_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = valid[STAGES];
  assign out_root  = root[STAGES];
  assign out_tag   = tag[STAGES];

  // Radicand is at least 2^32, so the root never drops under 2^16
  `OSP_ASSERT_IMP(a_root_floor, clk, rst, out_valid, out_root >= osp_pkg::ROOT_MIN)

endmodule

// ===== src/osp_div_pipe.sv =====
module osp_div_pipe #(
  parameter int ANGLE_BITS = osp_pkg::ANGLE_BITS_DEF,
  parameter int TAG_W      = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [osp_pkg::PROD_W-1:0] in_num,
  input  logic [osp_pkg::ROOT_W-1:0] in_den,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_valid,
  output logic [ANGLE_BITS-1:0]      out_quot,
  output logic [TAG_W-1:0]           out_tag
);

  localparam int STAGES = ANGLE_BITS;
  localparam int W      = osp_pkg::ROOT_W;
  localparam int PRE_LO = osp_pkg::QUOT_TOP - osp_pkg::NUM_SHIFT;

  logic                       valid [1:STAGES];
  logic [osp_pkg::PROD_W-1:0] num   [1:STAGES];
  logic [W-1:0]               den   [1:STAGES];
  logic [W-1:0]               rem   [1:STAGES];
  logic [ANGLE_BITS-1:0]      quot  [1:STAGES];
  logic [TAG_W-1:0]           tag   [1:STAGES];

  // One quotient bit per stage, from dividend bit QUOT_TOP-1 downward
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int J = osp_pkg::QUOT_TOP - 1 - k;
    logic                       cur_valid;
    logic [osp_pkg::PROD_W-1:0] cur_num;
    logic [W-1:0]               cur_den;
    logic [W-1:0]               cur_rem;
    logic [ANGLE_BITS-1:0]      cur_quot;
    logic [TAG_W-1:0]           cur_tag;
    logic                       nbit;
    logic [W:0]                 rem_sh;
    logic [W:0]                 diff;

    if (k == 0) begin : g_first
      assign cur_valid = in_valid;
      assign cur_num   = in_num;
      assign cur_den   = in_den;
      assign cur_rem   = W'(in_num[osp_pkg::PROD_W-1:PRE_LO]);
      assign cur_quot  = '0;
      assign cur_tag   = in_tag;
    end else begin : g_rest
      assign cur_valid = valid[k];
      assign cur_num   = num[k];
      assign cur_den   = den[k];
      assign cur_rem   = rem[k];
      assign cur_quot  = quot[k];
      assign cur_tag   = tag[k];
    end

    if (J >= osp_pkg::NUM_SHIFT) begin : g_bit
      assign nbit = cur_num[J-osp_pkg::NUM_SHIFT];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign rem_sh = {cur_rem, nbit};
    assign diff   = rem_sh - {1'b0, cur_den};

    // Advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= cur_valid;
      end
    end

    // Subtract when the divisor fits
    always_ff @(posedge clk) begin
      num[k+1] <= cur_num;
      den[k+1] <= cur_den;
      tag[k+1] <= cur_tag;
      if (rem_sh >= {1'b0, cur_den}) begin
        rem[k+1]  <= diff[W-1:0];
        quot[k+1] <= {cur_quot[ANGLE_BITS-2:0], 1'b1};
      end else begin
        rem[k+1]  <= rem_sh[W-1:0];
        quot[k+1] <= {cur_quot[ANGLE_BITS-2:0], 1'b0};
      end
    end
  end

  assign out_valid = valid[STAGES];
  assign out_quot  = quot[STAGES];
  assign out_tag   = tag[STAGES];

endmodule

// ===== src/osp_cordic_pipe.sv =====
`include "assert_macros.svh"

module osp_cordic_pipe #(
  parameter int ANGLE_BITS   = osp_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = osp_pkg::CORDIC_STEPS_DEF,
  parameter int TAG_W        = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [ANGLE_BITS-1:0]             in_angle,
  input  logic [TAG_W-1:0]                  in_tag,
  output logic                              out_valid,
  output logic signed [osp_pkg::TRIG_W-1:0] out_x,
  output logic signed [osp_pkg::TRIG_W-1:0] out_y,
  output logic [1:0]                        out_quad,
  output logic [TAG_W-1:0]                  out_tag
);

  localparam int TW = osp_pkg::TRIG_W;

  logic                 valid [1:CORDIC_STEPS];
  logic signed [TW-1:0] x     [1:CORDIC_STEPS];
  logic signed [TW-1:0] y     [1:CORDIC_STEPS];
  logic signed [TW-1:0] z     [1:CORDIC_STEPS];
  logic [1:0]           quad  [1:CORDIC_STEPS];
  logic [TAG_W-1:0]     tag   [1:CORDIC_STEPS];

  logic [osp_pkg::TURN_W-1:0] a32;

  // Widen the angle to a 32-bit turn
  assign a32 = osp_pkg::TURN_W'(in_angle) << (osp_pkg::TURN_W - ANGLE_BITS);

  // One rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                 cur_valid;
    logic signed [TW-1:0] cur_x;
    logic signed [TW-1:0] cur_y;
    logic signed [TW-1:0] cur_z;
    logic [1:0]           cur_quad;
    logic [TAG_W-1:0]     cur_tag;
    logic signed [TW-1:0] dx;
    logic signed [TW-1:0] dy;
    logic signed [TW-1:0] atn;

    if (i == 0) begin : g_first
      assign cur_valid = in_valid;
      assign cur_x     = osp_pkg::CORDIC_GAIN;
      assign cur_y     = '0;
      assign cur_z     = signed'({2'b00, a32[osp_pkg::TURN_W-3:0]});
      assign cur_quad  = a32[osp_pkg::TURN_W-1 -: 2];
      assign cur_tag   = in_tag;
    end else begin : g_rest
      assign cur_valid = valid[i];
      assign cur_x     = x[i];
      assign cur_y     = y[i];
      assign cur_z     = z[i];
      assign cur_quad  = quad[i];
      assign cur_tag   = tag[i];
    end

    assign dx  = cur_y >>> i;
    assign dy  = cur_x >>> i;
    assign atn = signed'(osp_pkg::ATAN_TURNS[i]);

    // Advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= cur_valid;
      end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk) begin
      quad[i+1] <= cur_quad;
      tag[i+1]  <= cur_tag;
      if (!cur_z[TW-1]) begin
        x[i+1] <= cur_x - dx;
        y[i+1] <= cur_y + dy;
        z[i+1] <= cur_z - atn;
      end else begin
        x[i+1] <= cur_x + dx;
        y[i+1] <= cur_y - dy;
        z[i+1] <= cur_z + atn;
      end
    end
  end

  assign out_valid = valid[CORDIC_STEPS];
  assign out_x     = x[CORDIC_STEPS];
  assign out_y     = y[CORDIC_STEPS];
  assign out_quad  = quad[CORDIC_STEPS];
  assign out_tag   = tag[CORDIC_STEPS];

  // Each rotation is registered
  `OSP_ASSERT_IMP(a_cordic_lat, clk, rst, out_valid, $past(in_valid, CORDIC_STEPS))

endmodule

// ===== src/orbital_star_position_update_unit.sv =====
// Throughput: one star per cycle; busy stays low, a new transaction may start every cycle.
// Results pass through the bit-per-stage square root (22 stages), divider (ANGLE_BITS stages)
// and CORDIC (CORDIC_STEPS stages); done pulses one cycle per result, no back-pressure.
// Reset (rst, synchronous) clears all pipeline valids and loads frame_time with 1074.
`include "assert_macros.svh"

module orbital_star_position_update_unit #(
  parameter int ANGLE_BITS   = osp_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = osp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cfg_wr_en,
  input  logic [osp_pkg::FRAME_W-1:0]        cfg_wr_data,
  input  logic [osp_pkg::RADIUS_W-1:0]       orbit_radius,
  input  logic [ANGLE_BITS-1:0]              angle,
  input  logic signed [osp_pkg::HEIGHT_W-1:0] height,
  input  logic                               last_star,
  output logic                               done,
  output logic [ANGLE_BITS-1:0]              new_angle,
  output logic signed [osp_pkg::POS_W-1:0]   pos_x,
  output logic signed [osp_pkg::POS_W-1:0]   pos_y,
  output logic signed [osp_pkg::HEIGHT_W-1:0] pos_z,
  output logic                               last_out
);

  localparam int TW     = osp_pkg::TRIG_W;
  localparam int MULT_W = osp_pkg::RADIUS_W + 1 + TW;

  typedef struct packed {
    logic [osp_pkg::PROD_W-1:0]   p;
    logic [osp_pkg::RADIUS_W-1:0] radius;
    logic [ANGLE_BITS-1:0]        angle;
    logic [osp_pkg::HEIGHT_W-1:0] height;
    logic                         last;
  } sq_tag_t;

  typedef struct packed {
    logic [osp_pkg::RADIUS_W-1:0] radius;
    logic [ANGLE_BITS-1:0]        angle;
    logic [osp_pkg::HEIGHT_W-1:0] height;
    logic                         last;
  } dv_tag_t;

  logic [osp_pkg::FRAME_W-1:0] frame_time;

  logic    in_valid;
  sq_tag_t in_tag;

  logic                       sq_valid;
  logic [osp_pkg::ROOT_W-1:0] sq_root;
  sq_tag_t                    sq_tag;
  dv_tag_t                    sq_fwd;

  logic                  div_valid;
  logic [ANGLE_BITS-1:0] div_quot;
  dv_tag_t               div_tag;

  logic [ANGLE_BITS:0]   step_next;
  logic                  ang_valid;
  logic [ANGLE_BITS-1:0] ang_na;
  dv_tag_t               ang_tag;

  logic                 cor_valid;
  logic signed [TW-1:0] cor_x;
  logic signed [TW-1:0] cor_y;
  logic [1:0]           cor_quad;
  dv_tag_t              cor_tag;

  logic                 map_valid;
  logic signed [TW-1:0] map_c;
  logic signed [TW-1:0] map_s;
  logic signed [TW-1:0] map_c_next;
  logic signed [TW-1:0] map_s_next;
  dv_tag_t              map_tag;

  logic                     mul_valid;
  logic signed [MULT_W-1:0] mul_x;
  logic signed [MULT_W-1:0] mul_y;
  dv_tag_t                  mul_tag;

  function automatic logic signed [osp_pkg::POS_W-1:0] round_sat(
    input logic signed [MULT_W-1:0] prod
  );
    logic signed [MULT_W-1:0] r;
    logic signed [MULT_W-1:0] pmax;
    logic signed [MULT_W-1:0] pmin;
    pmax = MULT_W'(signed'({1'b0, {(osp_pkg::POS_W-1){1'b1}}}));
    pmin = -pmax - MULT_W'(1);
    r = (prod + (MULT_W'(1) <<< (osp_pkg::TRIG_FRAC - 1))) >>> osp_pkg::TRIG_FRAC;
    if (r > pmax) begin
      return pmax[osp_pkg::POS_W-1:0];
    end else if (r < pmin) begin
      return pmin[osp_pkg::POS_W-1:0];
    end
    return r[osp_pkg::POS_W-1:0];
  endfunction

  assign busy = 1'b0;

  // Hold frame time; it must be written only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= osp_pkg::FRAME_TIME_RST;
    end else if (cfg_wr_en) begin
      frame_time <= cfg_wr_data;
    end
  end

  // Capture the transaction and form frame_time / pi
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_tag.p      <= osp_pkg::PROD_W'(frame_time) * osp_pkg::INV_PI;
    in_tag.radius <= orbit_radius;
    in_tag.angle  <= angle;
    in_tag.height <= height;
    in_tag.last   <= last_star;
  end

  // sqrt(radius + 1) in Q.16
  osp_sqrt_pipe #(
    .TAG_W($bits(sq_tag_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_rad   (osp_pkg::SQRT_IN_W'({({1'b0, in_tag.radius} + osp_pkg::RADIUS_ONE),
                                    {osp_pkg::RAD_FRAC{1'b0}}})),
    .in_tag   (in_tag),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  assign sq_fwd.radius = sq_tag.radius;
  assign sq_fwd.angle  = sq_tag.angle;
  assign sq_fwd.height = sq_tag.height;
  assign sq_fwd.last   = sq_tag.last;

  // Angle step, one guard bit for rounding
  osp_div_pipe #(
    .ANGLE_BITS(ANGLE_BITS),
    .TAG_W     ($bits(dv_tag_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_num   (sq_tag.p),
    .in_den   (sq_root),
    .in_tag   (sq_fwd),
    .out_valid(div_valid),
    .out_quot (div_quot),
    .out_tag  (div_tag)
  );

  // Round the step and advance the angle modulo one turn
  assign step_next = ({1'b0, div_quot} + (ANGLE_BITS+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else begin
      ang_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    ang_na  <= div_tag.angle + step_next[ANGLE_BITS-1:0];
    ang_tag <= div_tag;
  end

  osp_cordic_pipe #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS),
    .TAG_W       ($bits(dv_tag_t))
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ang_valid),
    .in_angle (ang_na),
    .in_tag   ({ang_tag.radius, ang_na, ang_tag.height, ang_tag.last}),
    .out_valid(cor_valid),
    .out_x    (cor_x),
    .out_y    (cor_y),
    .out_quad (cor_quad),
    .out_tag  (cor_tag)
  );

  // Rotate by the quadrant
  always_comb begin
    unique case (cor_quad)
      osp_pkg::QUAD_0: begin
        map_c_next = cor_x;
        map_s_next = cor_y;
      end
      osp_pkg::QUAD_1: begin
        map_c_next = -cor_y;
        map_s_next = cor_x;
      end
      osp_pkg::QUAD_2: begin
        map_c_next = -cor_x;
        map_s_next = -cor_y;
      end
      osp_pkg::QUAD_3: begin
        map_c_next = cor_y;
        map_s_next = -cor_x;
      end
      default: begin
        map_c_next = cor_x;
        map_s_next = cor_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= 1'b0;
      mul_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      map_valid <= cor_valid;
      mul_valid <= map_valid;
      done      <= mul_valid;
    end
  end

  // Scale by the radius, then round and saturate
  always_ff @(posedge clk) begin
    map_c   <= map_c_next;
    map_s   <= map_s_next;
    map_tag <= cor_tag;
    mul_x   <= MULT_W'(signed'({1'b0, map_tag.radius})) * MULT_W'(map_c);
    mul_y   <= MULT_W'(signed'({1'b0, map_tag.radius})) * MULT_W'(map_s);
    mul_tag <= map_tag;
    new_angle <= mul_tag.angle;
    pos_x     <= round_sat(mul_x);
    pos_y     <= round_sat(mul_y);
    pos_z     <= mul_tag.height;
    last_out  <= mul_tag.last;
  end

  // After its step, a result passes the angle, CORDIC, map, multiply and output registers
  `OSP_ASSERT_IMP(a_tail_lat, clk, rst, done, $past(div_valid, CORDIC_STEPS + 4))
  `OSP_ASSERT_NXT(a_accept, clk, rst, start && !busy, in_valid)

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = osp_pkg::ANGLE_BITS_DEF;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [AW-1:0]                angle;
    logic [osp_pkg::POS_W-1:0]    x;
    logic [osp_pkg::POS_W-1:0]    y;
    logic [osp_pkg::HEIGHT_W-1:0] z;
    logic                         last;
  } star_pos_t;

  // Star position predictor and pending-position store
  class star_scoreboard;
    star_pos_t pending[$];
    logic [osp_pkg::FRAME_W-1:0] frame_time;
    int errors;

    function new();
      frame_time = osp_pkg::FRAME_TIME_RST;
      errors = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Scale by radius, round, saturate
    function logic [osp_pkg::POS_W-1:0] scale(longint radius, longint trig);
      longint p;
      p = (radius * trig + (64'sd1 <<< 29)) >>> 30;
      if (p > 262143) p = 262143;
      if (p < -262144) p = -262144;
      return p[osp_pkg::POS_W-1:0];
    endfunction

    function void note_star(logic [osp_pkg::RADIUS_W-1:0] radius, logic [AW-1:0] ang,
                            logic [osp_pkg::HEIGHT_W-1:0] h, logic last);
      longint unsigned root, quot, stp;
      logic [AW-1:0] na;
      logic [31:0] a32;
      logic [1:0] quad;
      longint x, y, z, dx, dy, c, sn;
      star_pos_t e;
      root = isqrt((longint'(radius) + 256) << 24);
      quot = ((longint'(frame_time) * 64'd1367130551) << 16) / root;
      stp = (quot + (64'd1 << (47 - AW))) >> (48 - AW);
      na = ang + stp[AW-1:0];
      a32 = 32'(na) << (32 - AW);
      quad = a32[31:30];
      z = longint'(a32[29:0]);
      x = 652032874;
      y = 0;
      // Rotate toward the residual angle
      for (int i = 0; i < osp_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(osp_pkg::ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(osp_pkg::ATAN_TURNS[i]);
        end
      end
      case (quad)
        osp_pkg::QUAD_0: begin c = x;  sn = y;  end
        osp_pkg::QUAD_1: begin c = -y; sn = x;  end
        osp_pkg::QUAD_2: begin c = -x; sn = -y; end
        default: begin c = y; sn = -x; end
      endcase
      e.angle = na;
      e.x = scale(longint'(radius), c);
      e.y = scale(longint'(radius), sn);
      e.z = h;
      e.last = last;
      pending.push_back(e);
    endfunction

    function void field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_pos(star_pos_t got);
      star_pos_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected position, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      field("new_angle", 32'(e.angle), 32'(got.angle));
      field("pos_x", 32'(e.x), 32'(got.x));
      field("pos_y", 32'(e.y), 32'(got.y));
      field("pos_z", 32'(e.z), 32'(got.z));
      field("last_out", 32'(e.last), 32'(got.last));
    endfunction
  endclass

  logic clk, rst, start, busy, cfg_wr_en, last_star, done, last_out;
  logic [osp_pkg::FRAME_W-1:0] cfg_wr_data;
  logic [osp_pkg::RADIUS_W-1:0] orbit_radius;
  logic [AW-1:0] angle, new_angle;
  logic signed [osp_pkg::HEIGHT_W-1:0] height, pos_z;
  logic signed [osp_pkg::POS_W-1:0] pos_x, pos_y;
  star_scoreboard sb;
  int idle_pct;

  orbital_star_position_update_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .orbit_radius(orbit_radius), .angle(angle), .height(height),
    .last_star(last_star), .done(done), .new_angle(new_angle),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last_out(last_out)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Check each position on its done strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_pos({new_angle, pos_x, pos_y, pos_z, last_out});
  end

  task automatic send_star(logic [osp_pkg::RADIUS_W-1:0] r, logic [AW-1:0] a,
                           logic [osp_pkg::HEIGHT_W-1:0] h, logic l);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    orbit_radius <= r;
    angle <= a;
    height <= h;
    last_star <= l;
    do @(posedge clk); while (busy);
    sb.note_star(r, a, h, l);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_time(logic [osp_pkg::FRAME_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.frame_time = v;
  endtask

  task automatic random_stars(int n);
    logic [osp_pkg::RADIUS_W-1:0] r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: r = osp_pkg::RADIUS_W'($urandom_range(255));
        1: r = osp_pkg::RADIUS_W'($urandom_range(262143, 261000));
        default: r = osp_pkg::RADIUS_W'($urandom);
      endcase
      send_star(r, AW'($urandom), osp_pkg::HEIGHT_W'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [osp_pkg::RADIUS_W-1:0] radii[4] = '{18'd0, 18'd1, 18'd256, 18'd262143};
    logic [AW-1:0] angs[6] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    sb = new();
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    orbit_radius = '0;
    angle = '0;
    height = '0;
    last_star = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: radius and quadrant extremes at reset frame time
    foreach (radii[i])
      foreach (angs[j])
        send_star(radii[i], angs[j], (j % 2) ? 24'h800000 : 24'h7FFFFF, 1'(j % 2));
    drain();

    // Zero frame time keeps the angle
    write_frame_time(16'd0);
    send_star(18'h3FFFF, 16'h1234, 24'h000001, 1'b1);
    send_star(18'd0, 16'hFFFF, 24'hFFFFFF, 1'b0);
    idle_pct = 0;
    random_stars(100);
    drain();

    write_frame_time(16'hFFFF);
    idle_pct = 72;
    random_stars(180);
    drain();

    write_frame_time(osp_pkg::FRAME_W'($urandom));
    idle_pct = 0;
    random_stars(170);
    drain();

    write_frame_time(osp_pkg::FRAME_W'($urandom));
    idle_pct = 10;
    random_stars(180);
    drain();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/osp_pkg.sv
src/osp_sqrt_pipe.sv
src/osp_div_pipe.sv
src/osp_cordic_pipe.sv
src/orbital_star_position_update_unit.sv
tb/sv/tb.sv
